// ===== rtl/core/p2c_pkg.sv =====
// shared types and constants for the polar to cartesian scan projector
// no dependencies; imported by every module of the block
`default_nettype none

package p2c_pkg;

  // configuration port
  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_START_ANGLE = 2'd0,
    REG_ANGLE_STEP  = 2'd1,
    REG_MIN_RANGE   = 2'd2,
    REG_MAX_RANGE   = 2'd3
  } cfg_reg_t;

  // classification of a beam
  typedef enum logic [1:0] {
    KIND_NORMAL = 2'd0,
    KIND_BELOW  = 2'd1,
    KIND_FAR    = 2'd2
  } point_kind_t;

  // far points sit at 1e6 m
  localparam logic [29:0] FAR_RADIUS_MM = 30'd1000000000;

  // odd polynomial for sin(pi/2 * t), Q30, evaluated in Horner form
  localparam logic [30:0] SIN_C9 = 31'd172272;
  localparam int NUM_CELLS = 4;
  localparam logic [30:0] SIN_COEF [NUM_CELLS] = '{
    31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
  };

  typedef struct packed {
    logic [15:0] start_angle;
    logic [15:0] angle_step;
    logic [15:0] min_range_mm;
    logic [15:0] max_range_mm;
  } cfg_t;

  // one sine evaluation in flight: partial sum, argument, argument squared
  typedef struct packed {
    logic [30:0] p;
    logic [30:0] t;
    logic [30:0] u;
    logic [1:0]  quad;
  } lane_t;

  typedef struct packed {
    lane_t       sin_l;
    lane_t       cos_l;
    logic [29:0] radius;
    point_kind_t kind;
    logic        dense;
    logic        last;
  } beam_t;

  typedef struct packed {
    logic signed [30:0] x_mm;
    logic signed [30:0] y_mm;
    point_kind_t        kind;
    logic               dense;
    logic               last;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/scan_polar_to_cartesian.sv =====
// a beam runs through the front end's first and second slots, the polynomial cells and the
// back end's slot 1, slot 2 and output register; throughput: one beam per cycle unless the
//   output stalls; the sine runs as a row of four Horner cells, one multiply per lane each
// reset: synchronous rst clears all valid bits, angle to 0, dense flag to 1,
//   registers to their reset values; no clearing pass
`default_nettype none

module scan_polar_to_cartesian #(
  parameter int ANGLE_BITS = 16,
  parameter int RANGE_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [p2c_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [15:0] cfg_data,
  // beam input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [15:0] range_mm
  input  wire logic [0:0]  s_axis_tuser,  // [0] first_of_scan
  input  wire logic        s_axis_tlast,  // last_of_scan
  // point output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,  // [30:0] x_mm, [61:31] y_mm, [63:62] zero
  output logic [2:0]       m_axis_tuser,  // [1:0] point_kind, [2] scan_dense
  output logic             m_axis_tlast   // end_of_scan
);
  import p2c_pkg::*;

  localparam logic [15:0] RANGE_MASK = 16'((32'd1 << RANGE_BITS) - 32'd1);

  cfg_t    cfg;
  result_t res;

  beam_t              chain_beam  [NUM_CELLS+1];
  logic [NUM_CELLS:0] chain_valid;
  logic [NUM_CELLS:0] chain_ready;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_angle  <= 16'd0;
      cfg.angle_step   <= 16'd0;
      cfg.min_range_mm <= 16'd0;
      cfg.max_range_mm <= 16'hFFFF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_START_ANGLE: cfg.start_angle  <= cfg_data;
        REG_ANGLE_STEP:  cfg.angle_step   <= cfg_data;
        REG_MIN_RANGE:   cfg.min_range_mm <= cfg_data;
        REG_MAX_RANGE:   cfg.max_range_mm <= cfg_data;
        default: ;
      endcase
    end
  end

  // angle, classification and sine argument
  p2c_front #(
    .ANGLE_BITS (ANGLE_BITS),
    .RANGE_MASK (RANGE_MASK)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .range_mm      (s_axis_tdata),
    .first_of_scan (s_axis_tuser[0]),
    .last_of_scan  (s_axis_tlast),
    .out_valid     (chain_valid[0]),
    .out_ready     (chain_ready[0]),
    .out_beam      (chain_beam[0])
  );

  // row of polynomial cells
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    p2c_cell #(
      .COEF (SIN_COEF[k])
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[k]),
      .in_ready  (chain_ready[k]),
      .in_beam   (chain_beam[k]),
      .out_valid (chain_valid[k+1]),
      .out_ready (chain_ready[k+1]),
      .out_beam  (chain_beam[k+1])
    );
  end

  // final product, rounding and projection
  p2c_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chain_valid[NUM_CELLS]),
    .in_ready  (chain_ready[NUM_CELLS]),
    .in_beam   (chain_beam[NUM_CELLS]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  assign m_axis_tdata = {2'b00, res.y_mm, res.x_mm};
  assign m_axis_tuser = {res.dense, res.kind};
  assign m_axis_tlast = res.last;

`ifndef SYNTHESIS
  // invalid points carry zero coordinates
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser[1:0] == KIND_BELOW)) |-> (m_axis_tdata[61:0] == 62'd0))
    else $error("invalid point with nonzero coordinates");

  // an out-of-range point never reports a dense scan
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser[1:0] != KIND_NORMAL)) |-> !m_axis_tuser[2])
    else $error("dense flag set on out-of-range point");

  // padding bits stay clear and the point kind is never 3
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[63:62] == 2'b00) && (m_axis_tuser[1:0] != 2'd3))
    else $error("bad padding or point kind");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/p2c_front.sv =====
// front end: beam angle and dense state, range classification, sine argument
// uses p2c_pkg; feeds the first polynomial cell
`default_nettype none

module p2c_front #(
  parameter int ANGLE_BITS = 16,
  parameter logic [15:0] RANGE_MASK = 16'hFFFF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire p2c_pkg::cfg_t cfg,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [15:0]  range_mm,
  input  wire logic         first_of_scan,
  input  wire logic         last_of_scan,
  output logic              out_valid,
  input  wire logic         out_ready,
  output p2c_pkg::beam_t    out_beam
);
  import p2c_pkg::*;

  localparam int FRAC_BITS = ANGLE_BITS - 2;
  localparam int T_SHIFT = 32 - ANGLE_BITS;
  localparam logic [30:0] T_ONE = 31'd1 << 30;

  logic [ANGLE_BITS-1:0] beam_angle;
  logic                  dense_so_far;

  logic                  a_valid;
  logic                  a_ready;
  logic [ANGLE_BITS-1:0] a_angle;
  logic [29:0]           a_radius;
  point_kind_t           a_kind;
  logic                  a_dense;
  logic                  a_last;

  logic                  b_ready;

  logic [15:0]           range_m;
  logic [31:0]           step_ext;
  logic [31:0]           start_ext;
  logic [ANGLE_BITS-1:0] angle_next;
  point_kind_t           kind_next;
  logic [29:0]           radius_next;
  logic                  dense_next;
  logic [1:0]            quad_s;
  logic [1:0]            quad_c;

  // argument t in Q30 over a quarter turn, mirrored in odd quadrants, and t*t
  function automatic lane_t make_lane(input logic [1:0] quad,
                                      input logic [FRAC_BITS-1:0] frac);
    logic [30:0] t;
    logic [61:0] sq;
    lane_t       l;
    t = {1'b0, frac, {T_SHIFT{1'b0}}};
    if (quad[0]) begin
      t = T_ONE - t;
    end
    sq = {31'b0, t} * {31'b0, t};
    l.p = SIN_C9;
    l.t = t;
    l.u = sq[60:30];
    l.quad = quad;
    return l;
  endfunction

  assign b_ready  = !out_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  // next angle and classification of the incoming beam
  always_comb begin
    range_m   = range_mm & RANGE_MASK;
    step_ext  = {{16{cfg.angle_step[15]}}, cfg.angle_step};
    start_ext = {16'b0, cfg.start_angle};
    if (first_of_scan) begin
      angle_next = start_ext[ANGLE_BITS-1:0];
    end else begin
      angle_next = beam_angle + step_ext[ANGLE_BITS-1:0];
    end
    if (range_m < cfg.min_range_mm) begin
      kind_next   = KIND_BELOW;
      radius_next = 30'd0;
    end else if (range_m > cfg.max_range_mm) begin
      kind_next   = KIND_FAR;
      radius_next = FAR_RADIUS_MM;
    end else begin
      kind_next   = KIND_NORMAL;
      radius_next = {14'b0, range_m};
    end
    dense_next = (first_of_scan || dense_so_far) && (kind_next == KIND_NORMAL);
  end

  // scan state and first slot
  always_ff @(posedge clk) begin
    if (rst) begin
      beam_angle   <= '0;
      dense_so_far <= 1'b1;
      a_valid      <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= in_valid;
      end
      if (in_valid && a_ready) begin
        beam_angle   <= angle_next;
        dense_so_far <= dense_next;
      end
    end
    if (in_valid && a_ready) begin
      a_angle  <= angle_next;
      a_radius <= radius_next;
      a_kind   <= kind_next;
      a_dense  <= dense_next;
      a_last   <= last_of_scan;
    end
  end

  // cosine is the sine a quarter turn later
  assign quad_s = a_angle[ANGLE_BITS-1:ANGLE_BITS-2];
  assign quad_c = quad_s + 2'd1;

  // second slot: argument and its square for both lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_ready) begin
      out_valid <= a_valid;
    end
    if (a_valid && b_ready) begin
      out_beam.sin_l  <= make_lane(quad_s, a_angle[FRAC_BITS-1:0]);
      out_beam.cos_l  <= make_lane(quad_c, a_angle[FRAC_BITS-1:0]);
      out_beam.radius <= a_radius;
      out_beam.kind   <= a_kind;
      out_beam.dense  <= a_dense;
      out_beam.last   <= a_last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/p2c_cell.sv =====
// one Horner step of the sine polynomial for the sine and cosine lanes
// uses p2c_pkg; instances are chained between front and back end
`default_nettype none

module p2c_cell #(
  parameter logic [30:0] COEF = 31'd0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire p2c_pkg::beam_t in_beam,
  output logic               out_valid,
  input  wire logic          out_ready,
  output p2c_pkg::beam_t     out_beam
);
  import p2c_pkg::*;

  beam_t beam_next;

  // p <- COEF - (p * u) >> 30
  function automatic lane_t step(input lane_t l);
    logic [61:0] prod;
    logic [31:0] diff;
    lane_t       r;
    prod = {31'b0, l.p} * {31'b0, l.u};
    diff = {1'b0, COEF} - prod[61:30];
    r = l;
    r.p = diff[30:0];
    return r;
  endfunction

  assign in_ready = !out_valid || out_ready;

  // both lanes take one step, everything else passes through
  always_comb begin
    beam_next       = in_beam;
    beam_next.sin_l = step(in_beam.sin_l);
    beam_next.cos_l = step(in_beam.cos_l);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      out_beam <= beam_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/p2c_back.sv =====
// back end: final sine product, Q15 rounding, projection onto the radius
// uses p2c_pkg; takes the last polynomial cell, drives the output register
`default_nettype none

module p2c_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire p2c_pkg::beam_t in_beam,
  output logic               out_valid,
  input  wire logic          out_ready,
  output p2c_pkg::result_t   out_res
);
  import p2c_pkg::*;

  // slot 1: sine in Q30
  logic        mul_valid;
  logic        mul_ready;
  logic [31:0] mul_raw_s;
  logic [31:0] mul_raw_c;
  logic [1:0]  mul_quad_s;
  logic [1:0]  mul_quad_c;
  logic [29:0] mul_radius;
  point_kind_t mul_kind;
  logic        mul_dense;
  logic        mul_last;

  // slot 2: radius times Q15 magnitude
  logic        rnd_valid;
  logic        rnd_ready;
  logic [44:0] rnd_prod_s;
  logic [44:0] rnd_prod_c;
  logic        rnd_neg_s;
  logic        rnd_neg_c;
  point_kind_t rnd_kind;
  logic        rnd_dense;
  logic        rnd_last;

  logic        out_ready_i;

  function automatic logic [31:0] sine_q30(input lane_t l);
    logic [61:0] prod;
    prod = {31'b0, l.p} * {31'b0, l.t};
    return prod[61:30];
  endfunction

  // round Q30 to Q15 and clamp to the largest positive code
  function automatic logic [14:0] to_q15(input logic [31:0] raw);
    logic [32:0] sr;
    logic [17:0] q;
    sr = {1'b0, raw} + 33'd16384;
    q  = sr[32:15];
    return (q > 18'd32767) ? 15'h7FFF : q[14:0];
  endfunction

  // round to nearest mm, ties away from zero, then apply the sign
  function automatic logic [30:0] to_mm(input logic [44:0] prod, input logic neg);
    logic [45:0] rs;
    logic [30:0] v;
    rs = {1'b0, prod} + 46'd16384;
    v  = rs[45:15];
    return neg ? (31'd0 - v) : v;
  endfunction

  logic [14:0] mag_s;
  logic [14:0] mag_c;

  assign out_ready_i = !out_valid || out_ready;
  assign rnd_ready   = !rnd_valid || out_ready_i;
  assign mul_ready   = !mul_valid || rnd_ready;
  assign in_ready    = mul_ready;

  assign mag_s = to_q15(mul_raw_s);
  assign mag_c = to_q15(mul_raw_c);

  // slot 1
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (mul_ready) begin
      mul_valid <= in_valid;
    end
    if (in_valid && mul_ready) begin
      mul_raw_s  <= sine_q30(in_beam.sin_l);
      mul_raw_c  <= sine_q30(in_beam.cos_l);
      mul_quad_s <= in_beam.sin_l.quad;
      mul_quad_c <= in_beam.cos_l.quad;
      mul_radius <= in_beam.radius;
      mul_kind   <= in_beam.kind;
      mul_dense  <= in_beam.dense;
      mul_last   <= in_beam.last;
    end
  end

  // slot 2
  always_ff @(posedge clk) begin
    if (rst) begin
      rnd_valid <= 1'b0;
    end else if (rnd_ready) begin
      rnd_valid <= mul_valid;
    end
    if (mul_valid && rnd_ready) begin
      rnd_prod_s <= {15'b0, mul_radius} * {30'b0, mag_s};
      rnd_prod_c <= {15'b0, mul_radius} * {30'b0, mag_c};
      rnd_neg_s  <= mul_quad_s[1] && (mag_s != 15'd0);
      rnd_neg_c  <= mul_quad_c[1] && (mag_c != 15'd0);
      rnd_kind   <= mul_kind;
      rnd_dense  <= mul_dense;
      rnd_last   <= mul_last;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready_i) begin
      out_valid <= rnd_valid;
    end
    if (rnd_valid && out_ready_i) begin
      if (rnd_kind == KIND_BELOW) begin
        out_res.x_mm <= '0;
        out_res.y_mm <= '0;
      end else begin
        out_res.x_mm <= to_mm(rnd_prod_c, rnd_neg_c);
        out_res.y_mm <= to_mm(rnd_prod_s, rnd_neg_s);
      end
      out_res.kind  <= rnd_kind;
      out_res.dense <= rnd_dense;
      out_res.last  <= rnd_last;
    end
  end

endmodule

`default_nettype wire
